FILE: hdl/tcaoq_pkg.sv
// shared constants and types for the two-class age-ordered queue
package tcaoq_pkg;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PAYLOAD_WIDTH = 32;
  localparam int unsigned STAMP_WIDTH   = 16;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ0   = 2'd1,
    CMD_DEQ1   = 2'd2,
    CMD_OLDEST = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic [STAMP_WIDTH-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } chain_stat_t;

endpackage

FILE: hdl/two_class_age_ordered_queue_unit.sv
// top level: two class queues, oldest-first selection and result register
//
// channel   dir  tdata             tuser (low bit up)
// s_axis    in   payload[31:0]     cmd[1:0], item_class[2]
// m_axis    out  out_payload[31:0] status[1:0], out_class[2]
//
// every request is decoded and applied in the cycle it is accepted; its
// result appears in the output register on the next cycle
// sustained rate one request per cycle while m_axis_tready takes each result
// a stalled result holds the output register and blocks only new requests
// reset clears the cell valid bits, the arrival counter and the output valid
module two_class_age_ordered_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // payload[31:0]
  input  logic [2:0]  s_axis_tuser,   // cmd[1:0], item_class[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_payload[31:0]
  output logic [2:0]  m_axis_tuser    // status[1:0], out_class[2]
);

  tcaoq_pkg::cmd_e        cmd;
  logic                   in_class;
  logic                   fire;
  tcaoq_pkg::cell_ctrl_t  ctrl0, ctrl1;
  tcaoq_pkg::entry_t      head0, head1, new_entry;
  tcaoq_pkg::chain_stat_t stat0, stat1;
  logic [tcaoq_pkg::STAMP_WIDTH-1:0] stamp_q, stamp_d;
  logic [tcaoq_pkg::STAMP_WIDTH-1:0] age_diff;
  logic                   deq_req, deq_cls, deq_ok, enq_ok, enq_full;

  logic                   out_valid_q, out_valid_d;
  tcaoq_pkg::status_e     status_q, status_d;
  logic                   out_class_q, out_class_d;
  logic [31:0]            out_payload_q, out_payload_d;

  assign cmd       = tcaoq_pkg::cmd_e'(s_axis_tuser[1:0]);
  assign in_class  = s_axis_tuser[2];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire      = s_axis_tvalid && s_axis_tready;

  assign new_entry.payload = s_axis_tdata;
  assign new_entry.stamp   = stamp_q;

  // negative wrap-aware difference means class 0 head is older
  assign age_diff = head0.stamp - head1.stamp;

  always_comb begin
    deq_req = 1'b1;
    deq_cls = 1'b0;
    unique case (cmd)
      tcaoq_pkg::CMD_ENQ:  deq_req = 1'b0;
      tcaoq_pkg::CMD_DEQ0: deq_cls = 1'b0;
      tcaoq_pkg::CMD_DEQ1: deq_cls = 1'b1;
      tcaoq_pkg::CMD_OLDEST: begin
        priority if (stat0.empty) begin
          deq_cls = 1'b1;
        end else if (stat1.empty) begin
          deq_cls = 1'b0;
        end else begin
          deq_cls = !age_diff[tcaoq_pkg::STAMP_WIDTH-1];
        end
      end
      default: deq_req = 1'b0;
    endcase
  end

  assign deq_ok   = deq_req && !(deq_cls ? stat1.empty : stat0.empty);
  assign enq_full = in_class ? stat1.full : stat0.full;
  assign enq_ok   = !deq_req && !enq_full;

  assign ctrl0.enq = fire && enq_ok && !in_class;
  assign ctrl1.enq = fire && enq_ok && in_class;
  assign ctrl0.deq = fire && deq_ok && !deq_cls;
  assign ctrl1.deq = fire && deq_ok && deq_cls;

  tcaoq_chain u_chain0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl0),
    .entry_i (new_entry),
    .head_o  (head0),
    .stat_o  (stat0)
  );

  tcaoq_chain u_chain1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl1),
    .entry_i (new_entry),
    .head_o  (head1),
    .stat_o  (stat1)
  );

  assign stamp_d = (ctrl0.enq || ctrl1.enq) ? stamp_q + 1'b1 : stamp_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    out_class_d   = out_class_q;
    out_payload_d = out_payload_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d   = 1'b1;
      out_class_d   = 1'b0;
      out_payload_d = '0;
      priority if (!deq_req) begin
        status_d = enq_full ? tcaoq_pkg::ST_FULL : tcaoq_pkg::ST_OK;
      end else if (deq_ok) begin
        status_d      = tcaoq_pkg::ST_OK;
        out_class_d   = deq_cls;
        out_payload_d = deq_cls ? head1.payload : head0.payload;
      end else begin
        status_d = tcaoq_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      stamp_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      stamp_q     <= stamp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q      <= status_d;
    out_class_q   <= out_class_d;
    out_payload_q <= out_payload_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_payload_q;
  assign m_axis_tuser  = {out_class_q, status_q};

  a_chain0_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat0.empty && stat0.full)) else $error("class 0 chain empty and full");

  a_chain1_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat1.empty && stat1.full)) else $error("class 1 chain empty and full");

  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl0.enq || ctrl1.enq) |=> stamp_q == $past(stamp_q) + 1'b1)
    else $error("arrival counter did not advance on enqueue");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != tcaoq_pkg::ST_OK) |->
      (out_payload_q == '0 && !out_class_q))
    else $error("non-ok result carries data");

endmodule

FILE: hdl/tcaoq_cell.sv
// one storage cell of a queue chain: holds an entry, shifts towards the head
module tcaoq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcaoq_pkg::cell_ctrl_t ctrl_i,
  input  logic                prev_valid_i,
  input  logic                next_valid_i,
  input  tcaoq_pkg::entry_t   next_entry_i,
  input  tcaoq_pkg::entry_t   entry_i,
  output logic                valid_o,
  output tcaoq_pkg::entry_t   entry_o
);

  logic              valid_q, valid_d;
  tcaoq_pkg::entry_t entry_q, entry_d;
  logic              take_new;

  // the first free cell (cell 0, or one behind an occupied cell) takes the incoming entry
  assign take_new = ctrl_i.enq && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.deq) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (take_new) begin
      valid_d = 1'b1;
      entry_d = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

FILE: hdl/tcaoq_chain.sv
// one class queue as a row of cells, head always in the first cell
module tcaoq_chain (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcaoq_pkg::cell_ctrl_t  ctrl_i,
  input  tcaoq_pkg::entry_t      entry_i,
  output tcaoq_pkg::entry_t      head_o,
  output tcaoq_pkg::chain_stat_t stat_o
);

  logic              valid [tcaoq_pkg::DEPTH];
  tcaoq_pkg::entry_t entry [tcaoq_pkg::DEPTH];

  for (genvar i = 0; i < tcaoq_pkg::DEPTH; i++) begin : g_cell
    logic              prev_valid;
    logic              next_valid;
    tcaoq_pkg::entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid[i-1];
    end

    if (i == tcaoq_pkg::DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_valid = valid[i+1];
      assign next_entry = entry[i+1];
    end

    tcaoq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .entry_i      (entry_i),
      .valid_o      (valid[i]),
      .entry_o      (entry[i])
    );
  end

  assign head_o       = entry[0];
  assign stat_o.empty = !valid[0];
  assign stat_o.full  = valid[tcaoq_pkg::DEPTH-1];

endmodule
